@@ sv/ntp_delay_weighted_median_filter_defines.svh @@
// ----------------------------------------------------------------------------
// NTP delay weighted median filter: assertion macros
// Shared property wrappers for the concurrent checks of the filter.
// ----------------------------------------------------------------------------
`ifndef NTP_DELAY_WEIGHTED_MEDIAN_FILTER_DEFINES_SVH
`define NTP_DELAY_WEIGHTED_MEDIAN_FILTER_DEFINES_SVH

// check sampled on the rising clock edge, masked while reset is asserted
`define NTPDM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check sampled on the rising clock edge, also during reset
`define NTPDM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ sv/ntpdm_pkg.sv @@
// ----------------------------------------------------------------------------
// NTP delay weighted median filter package
// Sizes, configuration register indexes, the chain beat type and the weight
// lookup shared by the filter modules.
// ----------------------------------------------------------------------------
package ntpdm_pkg;

  localparam int WINDOW_MAX  = 16;
  localparam int WEIGHT_BITS = 8;

  localparam int DELAY_W   = 64;
  localparam int STAMP_W   = 64;
  localparam int COUNT_W   = 32;
  localparam int WLEN_W    = 5;
  localparam int WEIGHTS_W = 128;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 64;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int LEN_W = $clog2(WINDOW_MAX + 1);
  localparam int RUN_W = WEIGHT_BITS + $clog2(WINDOW_MAX + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_HIGH = 2'd2;

  // one candidate travelling down the cell row with its running sums
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [DELAY_W-1:0] cand;
    logic [RUN_W-1:0]   run;
    logic [RUN_W-1:0]   total;
  } pkt_t;

  // weight of window position pos (oldest first); bits past the registers read 0
  function automatic logic [WEIGHT_BITS-1:0] weight_at(
    input logic [WEIGHTS_W-1:0] weights,
    input logic [IDX_W-1:0]     pos
  );
    logic [WEIGHT_BITS-1:0] w;
    int                     bit_idx;
    w = '0;
    for (int b = 0; b < WEIGHT_BITS; b++) begin
      bit_idx = int'(pos) * WEIGHT_BITS + b;
      if (bit_idx < WEIGHTS_W) begin
        w[b] = weights[bit_idx];
      end
    end
    return w;
  endfunction

endpackage

@@ sv/ntpdm_cell.sv @@
// ----------------------------------------------------------------------------
// NTP delay median cell
// Holds one window delay. In the window, it adds its weight to the total of
// each passing beat, and to its run when its delay is at least the candidate.
// ----------------------------------------------------------------------------
module ntpdm_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          shift_i,
  input  logic [ntpdm_pkg::DELAY_W-1:0] val_i,
  output logic [ntpdm_pkg::DELAY_W-1:0] val_o,
  input  logic [ntpdm_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic                          in_win_i,
  input  ntpdm_pkg::pkt_t               pkt_i,
  output ntpdm_pkg::pkt_t               pkt_o
);
  import ntpdm_pkg::*;

  logic [DELAY_W-1:0] val_q;
  pkt_t               pkt_q, pkt_d;
  logic               ge;
  logic [RUN_W-1:0]   wt;

  assign ge = $signed(val_q) >= $signed(pkt_i.cand);
  assign wt = in_win_i ? RUN_W'(weight_i) : '0;

  always_comb begin
    pkt_d       = pkt_i;
    pkt_d.total = pkt_i.total + wt;
    pkt_d.run   = (in_win_i && ge) ? pkt_i.run + wt : pkt_i.run;
  end

  // advance the window by one place on a push
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      val_q <= val_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else begin
      pkt_q <= pkt_d;
    end
  end

  assign val_o = val_q;
  assign pkt_o = pkt_q;

endmodule

@@ sv/ntpdm_select.sv @@
// ----------------------------------------------------------------------------
// NTP delay median selector
// Takes the beats leaving the cell row and keeps the largest candidate whose
// running weight reaches half the total.
// ----------------------------------------------------------------------------
module ntpdm_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  ntpdm_pkg::pkt_t               pkt_i,
  output logic [ntpdm_pkg::DELAY_W-1:0] best_o,
  output logic                          done_o
);
  import ntpdm_pkg::*;

  logic [DELAY_W-1:0] best_q;
  logic               found_q;
  logic               done_q;
  logic               qualify;
  logic               better;

  // half the total, compared exactly as 2 * run >= total
  assign qualify = {pkt_i.run, 1'b0} >= {1'b0, pkt_i.total};
  assign better  = !found_q || ($signed(pkt_i.cand) > $signed(best_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= pkt_i.valid && pkt_i.last;
      if (clear_i) begin
        found_q <= 1'b0;
      end else if (pkt_i.valid && qualify && better) begin
        best_q  <= pkt_i.cand;
        found_q <= 1'b1;
      end
    end
  end

  assign best_o = best_q;
  assign done_o = done_q;

endmodule

@@ sv/ntp_delay_weighted_median_filter.sv @@
// ----------------------------------------------------------------------------
// NTP delay weighted median filter
// Round-trip delay from four NTP timestamps, with a weighted median over the
// last window_len delays, formed by a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one beat of four 32.32
//   timestamps. The delay is (receive - origin) + (arrival - transmit),
//   saturated to the signed 64-bit range. Output channel (out_valid_o /
//   out_ready_i) gives window_start, current_delay and median_delay once at
//   least L = window_len delays are held; during warm-up no beat comes out.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once; the user must make them only while the block is idle, as the
//   block does not enforce this. One item is worked on at a time. With a
//   result it passes ST_SUM (delay arithmetic), ST_RUN (inject the L
//   candidates into the row of WINDOW_MAX cells), ST_WAIT (drain the row)
//   and ST_FINISH; without one, ST_SUM goes straight to ST_FINISH. The
//   next item is taken once the block is back in ST_IDLE.
//   The finished result sits in an output register; a new item may be
//   accepted while it waits, but if that item also has a result it does
//   not finish until the receiver takes the earlier beat.
//   Reset clears the held count, the item counter and the registers to their
//   defaults (window_len 10, all weights 1); window contents are not cleared.
// ----------------------------------------------------------------------------
`include "ntp_delay_weighted_median_filter_defines.svh"

module ntp_delay_weighted_median_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ntpdm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ntpdm_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ntpdm_pkg::STAMP_W-1:0]   origin_time_i,
  input  logic [ntpdm_pkg::STAMP_W-1:0]   receive_time_i,
  input  logic [ntpdm_pkg::STAMP_W-1:0]   transmit_time_i,
  input  logic [ntpdm_pkg::STAMP_W-1:0]   arrival_time_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ntpdm_pkg::COUNT_W-1:0]   window_start_o,
  output logic signed [ntpdm_pkg::DELAY_W-1:0] current_delay_o,
  output logic signed [ntpdm_pkg::DELAY_W-1:0] median_delay_o
);
  import ntpdm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [WLEN_W-1:0]    window_len_q;
  logic [WEIGHTS_W-1:0] weights_q;
  logic [DELAY_W-1:0]   diff1_q, diff2_q, delay_q;
  logic [LEN_W-1:0]     held_q;
  logic [COUNT_W-1:0]   items_q;
  logic [IDX_W-1:0]     k_q;
  logic                 emit_q;
  logic                 out_valid_q;
  logic [COUNT_W-1:0]   window_start_q;
  logic [DELAY_W-1:0]   current_delay_q, median_delay_q;

  logic [LEN_W-1:0]     len_w;
  logic [DELAY_W-1:0]   sum_w, sat_w;
  logic                 ovf_w;
  logic                 last_inj_w;
  logic                 out_free_w;
  logic                 finish_go_w;
  logic                 shift_w;
  logic                 sel_clear_w;
  logic [DELAY_W-1:0]   best_w;
  logic                 sel_done_w;

  logic [DELAY_W-1:0]     val_w [WINDOW_MAX];
  logic [WEIGHT_BITS-1:0] weight_w [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]  in_win_w;
  pkt_t                   pkt_head_w;
  pkt_t                   pkt_w [WINDOW_MAX+1];

  // effective window length: zero acts as one, clamp at WINDOW_MAX
  always_comb begin
    if (window_len_q == '0) begin
      len_w = LEN_W'(1);
    end else if (int'(window_len_q) > WINDOW_MAX) begin
      len_w = LEN_W'(WINDOW_MAX);
    end else begin
      len_w = LEN_W'(window_len_q);
    end
  end

  // saturating add of the two wrapped differences
  assign sum_w = diff1_q + diff2_q;
  assign ovf_w = (diff1_q[DELAY_W-1] == diff2_q[DELAY_W-1]) &&
                 (sum_w[DELAY_W-1] != diff1_q[DELAY_W-1]);
  assign sat_w = !ovf_w ? sum_w :
                 diff1_q[DELAY_W-1] ? {1'b1, {(DELAY_W-1){1'b0}}} :
                                      {1'b0, {(DELAY_W-1){1'b1}}};

  assign last_inj_w  = ({1'b0, k_q} == LEN_W'(len_w - LEN_W'(1)));
  assign out_free_w  = !out_valid_q || out_ready_i;
  assign finish_go_w = (state_q == ST_FINISH) && (!emit_q || out_free_w);
  assign shift_w     = finish_go_w;
  assign sel_clear_w = (state_q == ST_SUM);

  // candidate injection at the head of the row, one window entry a cycle
  always_comb begin
    pkt_head_w       = '0;
    pkt_head_w.valid = (state_q == ST_RUN);
    pkt_head_w.last  = last_inj_w;
    pkt_head_w.cand  = val_w[k_q];
  end

  assign pkt_w[0] = pkt_head_w;

  for (genvar a = 0; a < WINDOW_MAX; a++) begin : g_cell
    logic [DELAY_W-1:0] val_in;
    if (a == 0) begin : g_head
      assign val_in = delay_q;
    end else begin : g_body
      assign val_in = val_w[a-1];
    end

    // cell a holds the delay pushed a items ago: window position L-1-a
    assign in_win_w[a] = (LEN_W'(a) < len_w);
    assign weight_w[a] = weight_at(weights_q, IDX_W'(len_w - LEN_W'(1) - LEN_W'(a)));

    ntpdm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift_w),
      .val_i    (val_in),
      .val_o    (val_w[a]),
      .weight_i (weight_w[a]),
      .in_win_i (in_win_w[a]),
      .pkt_i    (pkt_w[a]),
      .pkt_o    (pkt_w[a+1])
    );
  end

  ntpdm_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (sel_clear_w),
    .pkt_i   (pkt_w[WINDOW_MAX]),
    .best_o  (best_w),
    .done_o  (sel_done_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      window_len_q    <= WLEN_W'(10);
      weights_q       <= {(WEIGHTS_W / WEIGHT_BITS){WEIGHT_BITS'(1)}};
      diff1_q         <= '0;
      diff2_q         <= '0;
      delay_q         <= '0;
      held_q          <= '0;
      items_q         <= '0;
      k_q             <= '0;
      emit_q          <= 1'b0;
      out_valid_q     <= 1'b0;
      window_start_q  <= '0;
      current_delay_q <= '0;
      median_delay_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_WINDOW_LEN:   window_len_q <= cfg_data_i[WLEN_W-1:0];
          CFG_WEIGHTS_LOW:  weights_q[CFG_W-1:0] <= cfg_data_i;
          CFG_WEIGHTS_HIGH: weights_q[WEIGHTS_W-1:CFG_W] <= cfg_data_i;
          default:          ;
        endcase
      end

      // drop the output beat once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && !(finish_go_w && emit_q)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            diff1_q <= receive_time_i - origin_time_i;
            diff2_q <= arrival_time_i - transmit_time_i;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          delay_q <= sat_w;
          emit_q  <= (held_q >= len_w);
          k_q     <= '0;
          state_q <= (held_q >= len_w) ? ST_RUN : ST_FINISH;
        end
        ST_RUN: begin
          k_q <= k_q + IDX_W'(1);
          if (last_inj_w) begin
            state_q <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (sel_done_w) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (finish_go_w) begin
            if (emit_q) begin
              out_valid_q     <= 1'b1;
              window_start_q  <= items_q - COUNT_W'(len_w);
              current_delay_q <= delay_q;
              median_delay_q  <= best_w;
            end
            if (int'(held_q) < WINDOW_MAX) begin
              held_q <= held_q + LEN_W'(1);
            end
            items_q <= items_q + COUNT_W'(1);
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign window_start_o  = window_start_q;
  assign current_delay_o = current_delay_q;
  assign median_delay_o  = median_delay_q;

  `NTPDM_ASSERT(a_one_item_at_a_time, (in_valid_i && in_ready_o) |=> !in_ready_o,
    "second item accepted while one is in flight")
  `NTPDM_ASSERT_ALWAYS(a_held_bound, int'(held_q) <= WINDOW_MAX,
    "held count beyond window capacity")
  `NTPDM_ASSERT(a_result_from_finish, $rose(out_valid_o) |-> $past(state_q == ST_FINISH),
    "result raised outside the finish step")
  `NTPDM_ASSERT(a_select_done_in_wait, sel_done_w |-> (state_q == ST_WAIT),
    "median pass ended while not waiting for it")

endmodule

@@ tb/ntp_delay_weighted_median_filter_tb.sv @@
// ----------------------------------------------------------------------------
// NTP delay weighted median filter testbench
// Sends NTP timestamp exchanges through the filter with random idling on
// both channels. A local predictor works out each round-trip delay and the
// weighted median of the window, and every result beat is checked field by
// field. Directed extremes come first, then random traffic over many window
// and weight settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ntp_delay_weighted_median_filter_tb;

  import ntpdm_pkg::*;

  typedef logic [STAMP_W-1:0]        stamp_t;
  typedef logic signed [DELAY_W-1:0] delay_t;

  typedef struct {
    logic [COUNT_W-1:0] window_start;
    delay_t             current_delay;
    delay_t             median_delay;
  } median_result_t;

  localparam stamp_t MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam stamp_t MIN_NEG = 64'h8000_0000_0000_0000;
  localparam stamp_t ONE_SEC = 64'h0000_0001_0000_0000;

  localparam logic [WLEN_W-1:0]    RESET_LEN     = 5'd10;
  localparam logic [CFG_W-1:0]     UNIT_WEIGHTS  = 64'h0101_0101_0101_0101;
  localparam logic [CFG_W-1:0]     RAMP_LOW      = 64'h0807_0605_0403_0201;
  localparam logic [CFG_W-1:0]     RAMP_HIGH     = 64'h100F_0E0D_0C0B_0A09;
  localparam int                   DRAIN_CYCLES  = WINDOW_MAX + 24;
  localparam int                   RANDOM_PHASES = 12;
  localparam int                   PHASE_ITEMS   = 130;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  stamp_t               origin_time_i;
  stamp_t               receive_time_i;
  stamp_t               transmit_time_i;
  stamp_t               arrival_time_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic [COUNT_W-1:0]   window_start_o;
  delay_t               current_delay_o;
  delay_t               median_delay_o;

  // predictor state
  delay_t               delay_history[$];
  logic [COUNT_W-1:0]   exchange_count;
  logic [WLEN_W-1:0]    window_len;
  logic [WEIGHTS_W-1:0] filter_weights;
  median_result_t       awaited_medians[$];

  int unsigned          mismatch_count = 0;
  bit                   source_quiet   = 1'b0;
  bit                   sink_quiet     = 1'b0;

  ntp_delay_weighted_median_filter u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .origin_time_i   (origin_time_i),
    .receive_time_i  (receive_time_i),
    .transmit_time_i (transmit_time_i),
    .arrival_time_i  (arrival_time_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .window_start_o  (window_start_o),
    .current_delay_o (current_delay_o),
    .median_delay_o  (median_delay_o)
  );

  always #6 clk_i = ~clk_i;

  // (receive - origin) + (arrival - transmit), saturated to the signed range
  function automatic delay_t round_trip_delay(stamp_t origin, stamp_t receive,
                                              stamp_t transmit, stamp_t arrival);
    stamp_t outbound;
    stamp_t inbound;
    stamp_t total;
    outbound = receive - origin;
    inbound  = arrival - transmit;
    total    = outbound + inbound;
    if (outbound[63] == inbound[63] && total[63] != outbound[63]) begin
      total = outbound[63] ? MIN_NEG : MAX_POS;
    end
    return delay_t'(total);
  endfunction

  // largest delay whose weight from the top reaches half the window total
  function automatic delay_t weighted_median(int unsigned len);
    delay_t      vals[WINDOW_MAX];
    int unsigned wts[WINDOW_MAX];
    int unsigned total;
    int unsigned running;
    int unsigned base;
    delay_t      best;
    bit          found;
    total = 0;
    best  = '0;
    found = 1'b0;
    base  = delay_history.size() - len;
    for (int p = 0; p < len; p++) begin
      vals[p] = delay_history[base + p];
      wts[p]  = int'(filter_weights[p*WEIGHT_BITS +: WEIGHT_BITS]);
      total  += wts[p];
    end
    for (int p = 0; p < len; p++) begin
      running = 0;
      for (int q = 0; q < len; q++) begin
        if (vals[q] >= vals[p]) begin
          running += wts[q];
        end
      end
      if (2 * running >= total && (!found || vals[p] > best)) begin
        best  = vals[p];
        found = 1'b1;
      end
    end
    return best;
  endfunction

  function automatic void predict_exchange(stamp_t origin, stamp_t receive,
                                           stamp_t transmit, stamp_t arrival);
    delay_t         delay;
    int unsigned    len;
    median_result_t res;
    delay = round_trip_delay(origin, receive, transmit, arrival);
    len   = (window_len == 0) ? 1 : (window_len > WINDOW_MAX) ? WINDOW_MAX : window_len;
    if (delay_history.size() >= len) begin
      res.window_start  = exchange_count - COUNT_W'(len);
      res.current_delay = delay;
      res.median_delay  = weighted_median(len);
      awaited_medians.insert(awaited_medians.size(), res);
    end
    delay_history.insert(delay_history.size(), delay);
    if (delay_history.size() > WINDOW_MAX) begin
      void'(delay_history.pop_front());
    end
    exchange_count++;
  endfunction

  function automatic void flag_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
    end
  endfunction

  function automatic stamp_t small_offset();
    stamp_t v;
    v = $urandom_range(0, 15);
    return v - 64'd4;
  endfunction

  function automatic stamp_t corner_stamp();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return MIN_NEG;
      3: return MAX_POS;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] random_weights();
    logic [CFG_W-1:0] w;
    w = '0;
    case ($urandom_range(0, 5))
      0: w = '0;
      1: w = '1;
      2: begin
        for (int i = 0; i < 8; i++) begin
          w[i*WEIGHT_BITS +: WEIGHT_BITS] = WEIGHT_BITS'($urandom_range(0, 3));
        end
      end
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // write all three registers, junk in the unused bits of the length
  task automatic configure(input logic [WLEN_W-1:0] len, input logic [CFG_W-1:0] w_low,
                           input logic [CFG_W-1:0] w_high);
    logic [CFG_W-1:0] len_word;
    len_word        = {$urandom, $urandom};
    len_word[4:0]   = len;
    cfg_we_i       <= 1'b1;
    cfg_idx_i      <= CFG_WINDOW_LEN;
    cfg_data_i     <= len_word;
    @(posedge clk_i);
    cfg_idx_i      <= CFG_WEIGHTS_LOW;
    cfg_data_i     <= w_low;
    @(posedge clk_i);
    cfg_idx_i      <= CFG_WEIGHTS_HIGH;
    cfg_data_i     <= w_high;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    window_len      = len;
    filter_weights  = {w_high, w_low};
  endtask

  task automatic send_item(input stamp_t origin, input stamp_t receive,
                           input stamp_t transmit, input stamp_t arrival);
    int gap;
    if ($urandom_range(0, 31) == 0) source_quiet = !source_quiet;
    gap = source_quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    origin_time_i   <= origin;
    receive_time_i  <= receive;
    transmit_time_i <= transmit;
    arrival_time_i  <= arrival;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_exchange(origin, receive, transmit, arrival);
  endtask

  task automatic send_random_exchange();
    stamp_t origin;
    stamp_t receive;
    stamp_t transmit;
    stamp_t arrival;
    origin = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        // tight delays so that equal values turn up often
        receive  = origin + small_offset();
        transmit = receive + stamp_t'($urandom_range(0, 255));
        arrival  = transmit + small_offset();
      end
      5, 6: begin
        receive  = origin + {$urandom_range(0, 2), $urandom} - {32'd0, $urandom};
        transmit = receive + {32'd0, $urandom};
        arrival  = transmit + {$urandom_range(0, 2), $urandom} - {32'd0, $urandom};
      end
      7, 8: begin
        receive  = {$urandom, $urandom};
        transmit = {$urandom, $urandom};
        arrival  = {$urandom, $urandom};
      end
      default: begin
        origin   = corner_stamp();
        receive  = corner_stamp();
        transmit = corner_stamp();
        arrival  = corner_stamp();
      end
    endcase
    send_item(origin, receive, transmit, arrival);
  endtask

  // drop valid, wait for every result, then let the pipeline settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (awaited_medians.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic test_default_window();
    stamp_t base;
    send_item('0, '0, '0, '0);
    send_item('1, '1, '1, '1);
    send_item('0, MAX_POS, '0, MAX_POS);
    send_item(MIN_NEG, '0, MIN_NEG, '0);
    send_item('1, '0, 64'd5, 64'd5);
    send_item('0, MAX_POS, ONE_SEC, '0);
    // four equal delays of one second from scattered bases, some wrapping
    for (int i = 0; i < 4; i++) begin
      base = stamp_t'(i) * 64'h5555_5555_5555_5555;
      send_item(base, base + (ONE_SEC >> 1), base + ONE_SEC, base + ONE_SEC + (ONE_SEC >> 1));
    end
    send_item('0, ONE_SEC, ONE_SEC, ONE_SEC);
    send_item(ONE_SEC, '0, '0, '0);
    wait_drained();
  endtask

  task automatic test_window_length_limits();
    configure(5'd0, UNIT_WEIGHTS, UNIT_WEIGHTS);
    repeat (2) send_random_exchange();
    wait_drained();
    // longer than the store: no results until the held count is WINDOW_MAX
    configure(5'd31, RAMP_LOW, RAMP_HIGH);
    repeat (3) send_random_exchange();
    wait_drained();
    configure(5'd3, RAMP_LOW, RAMP_HIGH);
    send_random_exchange();
    wait_drained();
  endtask

  task automatic test_weight_extremes();
    configure(5'd5, '0, '0);
    repeat (2) send_random_exchange();
    wait_drained();
    configure(5'd16, '1, '1);
    send_random_exchange();
    wait_drained();
  endtask

  task automatic test_random_traffic();
    logic [WLEN_W-1:0] len;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: len = WLEN_W'($urandom_range(0, 1));
        1: len = WLEN_W'($urandom_range(16, 31));
        default: len = WLEN_W'($urandom_range(2, 15));
      endcase
      configure(len, random_weights(), random_weights());
      repeat (PHASE_ITEMS) send_random_exchange();
      wait_drained();
    end
  endtask

  // result sink with random back-pressure
  initial begin
    int stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_quiet = !sink_quiet;
      stall = sink_quiet ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    median_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_medians.size() == 0) begin
        flag_mismatch("unexpected beat, current_delay", 'x, current_delay_o);
      end else begin
        want = awaited_medians.pop_front();
        if (window_start_o !== want.window_start) begin
          flag_mismatch("window_start", want.window_start, window_start_o);
        end
        if (current_delay_o !== want.current_delay) begin
          flag_mismatch("current_delay", want.current_delay, current_delay_o);
        end
        if (median_delay_o !== want.median_delay) begin
          flag_mismatch("median_delay", want.median_delay, median_delay_o);
        end
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_WINDOW_LEN;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    origin_time_i   = '0;
    receive_time_i  = '0;
    transmit_time_i = '0;
    arrival_time_i  = '0;
    exchange_count  = '0;
    window_len      = RESET_LEN;
    filter_weights  = {UNIT_WEIGHTS, UNIT_WEIGHTS};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_window();
    test_window_length_limits();
    test_weight_extremes();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
